FILE: sv/ascp_pkg.sv
// ascp_pkg: character codes, event codes and the mod-999 digit step
// shared by the parser core and the top level of the command parser
// no dependencies
package ascp_pkg;

  localparam int ByteW   = 8;
  localparam int EventW  = 3;
  localparam int AddrW   = 32;
  localparam int RemW    = 10;
  localparam int CsumW   = 16;
  localparam int TimeMod = 999;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [EventW-1:0] event_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [RemW-1:0]   rem_t;
  typedef logic [CsumW-1:0]  csum_t;

  localparam byte_t CH_TILDE = 8'h7E;  // '~'
  localparam byte_t CH_QUERY = 8'h3F;  // '?'
  localparam byte_t CH_PUSH  = 8'h40;  // '@'
  localparam byte_t CH_T     = 8'h54;  // 'T'
  localparam byte_t CH_COLON = 8'h3A;  // ':'
  localparam byte_t CH_CR    = 8'h0D;  // carriage return
  localparam byte_t CH_STAR  = 8'h2A;  // '*'
  localparam byte_t CH_COMMA = 8'h2C;  // ','
  localparam byte_t CH_ZERO  = 8'h30;  // '0'
  localparam byte_t CH_NINE  = 8'h39;  // '9'

  localparam event_t EV_TIME_OK   = 3'd0;
  localparam event_t EV_TIME_BAD  = 3'd1;
  localparam event_t EV_DESCRIBE  = 3'd2;
  localparam event_t EV_QUERY     = 3'd3;
  localparam event_t EV_PUSH_BYTE = 3'd4;
  localparam event_t EV_PUSH_NONE = 3'd5;

  localparam addr_t ADDR_RESET = 32'h2020_2020;

  typedef struct packed {
    logic busy;       // output slot holds a result
    logic step;       // parser consumes the staged byte this cycle
  } ascp_ctl_t;

  function automatic logic is_digit(byte_t b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // (rem*10 + d) mod 999 via parallel threshold compares
  function automatic rem_t mod999_step(rem_t rem, logic [3:0] d);
    logic [13:0] x;
    logic [3:0]  q;
    logic [13:0] r;
    x = 14'(rem) * 14'd10 + 14'(d);
    q = '0;
    for (int k = 1; k <= 10; k++) begin
      if (x >= 14'(k * TimeMod)) q = q + 4'd1;
    end
    r = x - 14'(q) * 14'(TimeMod);
    return r[RemW-1:0];
  endfunction

endpackage

FILE: sv/ascp_core.sv
// ascp_core: parse state machine and result register
// depends on ascp_pkg
module ascp_core import ascp_pkg::*; #(
  parameter int ADDR_LEN = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  byte_t     rx_byte,
  input  logic      burst_end,
  input  addr_t     dev_addr,
  input  logic      out_ready,
  output logic      out_valid,
  output event_t    out_kind
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_BCAST, PH_TIME, PH_CSUM, PH_ADDR, PH_SEP, PH_FIELD, PH_PAYLOAD
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] addr_idx_r, addr_idx_nxt;
  logic       mism_r, mism_nxt;
  logic       is_push_r, is_push_nxt;
  rem_t       rem_r, rem_nxt;
  csum_t      csum_r, csum_nxt;
  logic       out_valid_r, out_valid_nxt;
  event_t     out_kind_r, out_kind_nxt;

  logic        ev_valid;
  event_t      ev_kind;
  logic [3:0]  digit;
  logic [63:0] addr_wide;
  logic [2:0]  ch_sel;
  byte_t       addr_ch;

  assign digit      = 4'(rx_byte - CH_ZERO);
  assign addr_wide  = {32'b0, dev_addr};
  assign ch_sel     = 3'(ADDR_LEN - 1) - addr_idx_r;
  assign addr_ch    = addr_wide[{ch_sel, 3'b000} +: ByteW];

  always_comb begin
    phase_nxt    = phase_r;
    addr_idx_nxt = addr_idx_r;
    mism_nxt     = mism_r;
    is_push_nxt  = is_push_r;
    rem_nxt      = rem_r;
    csum_nxt     = csum_r;
    ev_valid     = 1'b0;
    ev_kind      = EV_TIME_OK;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == CH_TILDE) begin
          phase_nxt = burst_end ? PH_IDLE : PH_BCAST;
        end else if (rx_byte == CH_QUERY || rx_byte == CH_PUSH) begin
          is_push_nxt  = (rx_byte == CH_PUSH);
          addr_idx_nxt = '0;
          mism_nxt     = 1'b0;
          phase_nxt    = burst_end ? PH_IDLE : PH_ADDR;
        end
      end
      PH_BCAST: begin
        phase_nxt = PH_IDLE;
        if (rx_byte == CH_T) begin
          rem_nxt  = '0;
          csum_nxt = '0;
          if (burst_end) begin
            // empty time and checksum always agree
            ev_valid = 1'b1;
            ev_kind  = EV_TIME_OK;
          end else begin
            phase_nxt = PH_TIME;
          end
        end
      end
      PH_TIME: begin
        if (is_digit(rx_byte)) rem_nxt = mod999_step(rem_r, digit);
        if (burst_end) begin
          // checksum stays zero here
          ev_valid  = 1'b1;
          ev_kind   = (rem_nxt == '0) ? EV_TIME_OK : EV_TIME_BAD;
          phase_nxt = PH_IDLE;
        end else if (rx_byte == CH_COLON) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (is_digit(rx_byte)) csum_nxt = 16'(csum_r * 16'd10 + 16'(digit));
        if (burst_end || rx_byte == CH_CR) begin
          ev_valid  = 1'b1;
          ev_kind   = ({6'b0, rem_r} == csum_nxt) ? EV_TIME_OK : EV_TIME_BAD;
          phase_nxt = PH_IDLE;
        end
      end
      PH_ADDR: begin
        mism_nxt = mism_r | (rx_byte != addr_ch);
        if (burst_end) begin
          phase_nxt = PH_IDLE;
        end else if (addr_idx_r == 3'(ADDR_LEN - 1)) begin
          phase_nxt = mism_nxt ? PH_IDLE : PH_SEP;
        end else begin
          addr_idx_nxt = addr_idx_r + 3'd1;
        end
      end
      PH_SEP: begin
        phase_nxt = (rx_byte == CH_COMMA && !burst_end) ? PH_FIELD : PH_IDLE;
      end
      PH_FIELD: begin
        phase_nxt = PH_IDLE;
        if (is_push_r) begin
          if (burst_end) begin
            ev_valid = 1'b1;
            ev_kind  = EV_PUSH_NONE;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          ev_valid = 1'b1;
          ev_kind  = (rx_byte == CH_STAR) ? EV_DESCRIBE : EV_QUERY;
        end
      end
      PH_PAYLOAD: begin
        ev_valid = 1'b1;
        ev_kind  = EV_PUSH_BYTE;
        if (burst_end) phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    if (step) begin
      out_valid_nxt = ev_valid;
      out_kind_nxt  = ev_kind;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      addr_idx_r  <= '0;
      mism_r      <= 1'b0;
      is_push_r   <= 1'b0;
      rem_r       <= '0;
      csum_r      <= '0;
      out_valid_r <= 1'b0;
      out_kind_r  <= EV_TIME_OK;
    end else begin
      if (step) begin
        phase_r    <= phase_nxt;
        addr_idx_r <= addr_idx_nxt;
        mism_r     <= mism_nxt;
        is_push_r  <= is_push_nxt;
        rem_r      <= rem_nxt;
        csum_r     <= csum_nxt;
      end
      out_valid_r <= out_valid_nxt;
      out_kind_r  <= out_kind_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

endmodule

FILE: sv/addressed_serial_command_parser_unit.sv
// addressed_serial_command_parser_unit: top level of the serial command parser
// holds the input stage and the address register, instantiates ascp_core
// depends on ascp_pkg and ascp_core
//
// usage
//   in_* channel: one received byte per transaction (in_rx_byte) with
//   in_burst_end set when no further byte is waiting behind it
//   out_* channel: zero or one result per byte, out_event_kind gives
//   time accepted/rejected, describe request, field query, push data byte
//   or empty push
//   cfg_* channel: writes the four address characters, first character in
//   the top byte; cfg_ready is always high, write only while idle
// timing
//   one byte per cycle sustained while out_ready keeps the result slot free; a
//   byte waits in the input register until the parser steps on it, and its result
//   is loaded into the result register, which drives out_valid, at that step; all parsing
//   is one pass of logic between the input register and the result register
// reset and stall
//   rst_n (synchronous, active low) returns the parser to idle, clears the
//   running remainder and checksum and loads the address with four spaces
//   when out_ready is low with a result waiting, the staged byte holds and
//   in_ready falls once the input register is occupied too
module addressed_serial_command_parser_unit import ascp_pkg::*; #(
  parameter int ADDR_LEN = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  byte_t  in_rx_byte,
  input  logic   in_burst_end,
  output logic   out_valid,
  input  logic   out_ready,
  output event_t out_event_kind,
  input  logic   cfg_valid,
  output logic   cfg_ready,
  input  addr_t  cfg_device_address
);

  // input stage
  logic      in_valid_r, in_valid_nxt;
  byte_t     in_byte_r;
  logic      in_last_r;
  addr_t     dev_addr_r;
  ascp_ctl_t ctl;
  logic      in_take;

  // the staged byte moves on when the result slot is free or being drained
  assign ctl.busy  = out_valid;
  assign ctl.step  = in_valid_r && (!ctl.busy || out_ready);
  assign in_ready  = !in_valid_r || ctl.step;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (ctl.step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      dev_addr_r <= ADDR_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_valid && cfg_ready) dev_addr_r <= cfg_device_address;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
      in_last_r <= in_burst_end;
    end
  end

  ascp_core #(
    .ADDR_LEN (ADDR_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (ctl.step),
    .rx_byte   (in_byte_r),
    .burst_end (in_last_r),
    .dev_addr  (dev_addr_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_kind  (out_event_kind)
  );

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for addressed_serial_command_parser_unit
// drives byte bursts with burst flags, predicts each event in step, checks out_event_kind
// depends on ascp_pkg and addressed_serial_command_parser_unit
`timescale 1ns / 100ps

module tb_top;
  import ascp_pkg::*;

  localparam int ADDR_LEN     = 4;
  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE       = 6;         // margin for the pipe to settle after the last event
  localparam int HOLD_CYCLES  = 200;       // long receiver hold-off
  localparam int TIMEOUT_NS   = 3_000_000;

  // parser phases of the bench's own copy of the parser
  typedef enum logic [3:0] {
    PH_IDLE, PH_BCAST, PH_TIME, PH_CSUM, PH_ADDR, PH_SEP, PH_FIELD, PH_PAYLOAD
  } parse_phase_e;

  logic   clk;
  logic   rst_n              = 1'b0;
  logic   in_valid           = 1'b0;
  logic   in_ready;
  byte_t  in_rx_byte         = '0;
  logic   in_burst_end       = 1'b0;
  logic   out_valid;
  logic   out_ready          = 1'b0;
  event_t out_event_kind;
  logic   cfg_valid          = 1'b0;
  logic   cfg_ready;
  addr_t  cfg_device_address = '0;

  addressed_serial_command_parser_unit #(
    .ADDR_LEN (ADDR_LEN)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_burst_end       (in_burst_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address)
  );

  // predicted parser state, the bench's own copy
  parse_phase_e  phase;
  int            addr_pos;
  logic          addr_wrong;
  logic          is_push;
  logic [31:0]   time_acc;
  int            time_rem;         // time digits mod 999, kept digit by digit
  logic [15:0]   csum_acc;
  logic [31:0]   dev_time;
  byte_t         cur_field;
  addr_t         dev_addr;

  event_t        expected_events[$];  // events still owed by the block
  byte_t         burst[$];            // bytes of the burst being built
  int            parsed_bytes;        // bytes that were not simply dropped in idle
  int            mismatches;
  event_t        want_ev;

  // idling knobs, percentages
  int            send_idle_pct;
  int            stall_pct;
  // long hold-off request, served by the receiver process
  int            hold_asked;
  int            hold_done;
  int            hold_left;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // hard limit on the whole run
  initial begin
    #TIMEOUT_NS;
    $display("[addressed_serial_command_parser_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // reference parser
  // ---------------------------------------------------------------------------

  function automatic logic is_decimal(byte_t b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic byte_t addr_char(int idx);
    return byte_t'(dev_addr >> ((ADDR_LEN - 1 - idx) * 8));
  endfunction

  function automatic void reset_parser();
    phase        = PH_IDLE;
    addr_pos     = 0;
    addr_wrong   = 1'b0;
    is_push      = 1'b0;
    time_acc     = '0;
    time_rem     = 0;
    csum_acc     = '0;
    dev_time     = '0;
    cur_field    = '0;
    dev_addr     = ADDR_RESET;
    parsed_bytes = 0;
    mismatches   = 0;
  endfunction

  // time verdict: remainder of the time digits against the checksum
  function automatic event_t close_time();
    phase = PH_IDLE;
    if (time_rem == int'(csum_acc)) begin
      dev_time = time_acc;
      return EV_TIME_OK;
    end
    return EV_TIME_BAD;
  endfunction

  // one accepted byte: advance the parser and queue the event it gives, if any
  function automatic void predict_byte(byte_t b, logic last);
    int     d;
    logic   has_ev;
    event_t ev;
    has_ev = 1'b0;
    ev     = EV_TIME_OK;
    d      = int'(b) - int'(CH_ZERO);
    if (phase != PH_IDLE || b == CH_TILDE || b == CH_QUERY || b == CH_PUSH)
      parsed_bytes++;
    case (phase)
      PH_IDLE: begin
        // a lead byte starts a message only when more bytes follow it in the burst
        if (b == CH_TILDE) begin
          phase = last ? PH_IDLE : PH_BCAST;
        end else if (b == CH_QUERY || b == CH_PUSH) begin
          is_push    = (b == CH_PUSH);
          addr_pos   = 0;
          addr_wrong = 1'b0;
          phase      = last ? PH_IDLE : PH_ADDR;
        end
      end
      PH_BCAST: begin
        phase = PH_IDLE;
        if (b == CH_T) begin
          time_acc = '0;
          time_rem = 0;
          csum_acc = '0;
          if (last) begin
            has_ev = 1'b1;
            ev     = close_time();
          end else begin
            phase = PH_TIME;
          end
        end
      end
      PH_TIME: begin
        if (is_decimal(b)) begin
          time_acc = time_acc * 10 + d;
          time_rem = (time_rem * 10 + d) % TimeMod;
        end
        if (last) begin
          has_ev = 1'b1;
          ev     = close_time();
        end else if (b == CH_COLON) begin
          phase = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (is_decimal(b)) csum_acc = 16'(csum_acc * 10 + d);
        if (last || b == CH_CR) begin
          has_ev = 1'b1;
          ev     = close_time();
        end
      end
      PH_ADDR: begin
        // every address byte is compared, the verdict waits for the last one
        if (b != addr_char(addr_pos)) addr_wrong = 1'b1;
        if (last) begin
          phase = PH_IDLE;
        end else if (addr_pos + 1 >= ADDR_LEN) begin
          phase = addr_wrong ? PH_IDLE : PH_SEP;
        end else begin
          addr_pos++;
        end
      end
      PH_SEP: begin
        phase = (b == CH_COMMA && !last) ? PH_FIELD : PH_IDLE;
      end
      PH_FIELD: begin
        cur_field = b;
        phase     = PH_IDLE;
        if (is_push) begin
          if (last) begin
            has_ev = 1'b1;
            ev     = EV_PUSH_NONE;
          end else begin
            phase = PH_PAYLOAD;
          end
        end else begin
          has_ev = 1'b1;
          ev     = (b == CH_STAR) ? EV_DESCRIBE : EV_QUERY;
        end
      end
      PH_PAYLOAD: begin
        // any byte value is payload until the burst runs dry
        has_ev = 1'b1;
        ev     = EV_PUSH_BYTE;
        if (last) phase = PH_IDLE;
      end
      default: begin
        phase = PH_IDLE;
      end
    endcase
    if (has_ev) expected_events.push_back(ev);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: receiver stalls and the event checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left > 0) begin
      // long hold-off in progress, lets the block fill up
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      out_ready <= 1'b0;
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every accepted event against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: event mismatch, expected none, actual %0d", $time, out_event_kind);
        mismatches++;
      end else begin
        want_ev = expected_events.pop_front();
        if (out_event_kind !== want_ev) begin
          $display("%0t: event mismatch, expected %0d, actual %0d",
                   $time, want_ev, out_event_kind);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one byte transaction, with an optional idle gap in front of it
  task automatic send_byte(input byte_t b, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_burst_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, last);
  endtask

  // send the built burst, flagging its final byte as the end of the burst
  task automatic send_burst();
    int n;
    int i;
    n = burst.size();
    for (i = 0; i < n; i++) send_byte(burst[i], i == n - 1);
    burst.delete();
  endtask

  // stop sending, let every owed event come out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_address(input addr_t value);
    cfg_valid          <= 1'b1;
    cfg_device_address <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dev_addr = value;
  endtask

  // ---------------------------------------------------------------------------
  // burst builders
  // ---------------------------------------------------------------------------

  // a non-digit byte other than the given terminator
  function automatic byte_t filler_byte(byte_t stop);
    byte_t b;
    do b = byte_t'($urandom_range(255));
    while (is_decimal(b) || b == stop);
    return b;
  endfunction

  // the address characters, one of them corrupted when bad_pos is in range
  function automatic void put_address(int bad_pos);
    byte_t c;
    int    i;
    for (i = 0; i < ADDR_LEN; i++) begin
      c = addr_char(i);
      if (i == bad_pos) c = c ^ byte_t'($urandom_range(255, 1));
      burst.push_back(c);
    end
  endfunction

  // time broadcast with stray bytes, mostly a matching checksum
  function automatic void add_time_msg();
    int    ndig;
    int    rem;
    int    csum;
    int    d;
    int    i;
    byte_t digs[$];
    ndig = ($urandom_range(9) == 0) ? $urandom_range(14, 10) : $urandom_range(6, 0);
    rem  = 0;
    burst.push_back(CH_TILDE);
    burst.push_back(CH_T);
    for (i = 0; i < ndig; i++) begin
      d   = $urandom_range(9);
      rem = (rem * 10 + d) % TimeMod;
      burst.push_back(byte_t'(CH_ZERO + d));
      if ($urandom_range(7) == 0) burst.push_back(filler_byte(CH_COLON));
    end
    burst.push_back(CH_COLON);
    // wrong checksums, some long enough to wrap the 16-bit sum
    csum = ($urandom_range(4) == 0) ? $urandom_range(99999) : rem;
    do begin
      digs.push_front(byte_t'(CH_ZERO + csum % 10));
      csum = csum / 10;
    end while (csum > 0);
    if ($urandom_range(6) == 0) digs.push_front(CH_ZERO);
    foreach (digs[i]) begin
      burst.push_back(digs[i]);
      if ($urandom_range(9) == 0) burst.push_back(filler_byte(CH_CR));
    end
    burst.push_back(CH_CR);
  endfunction

  // query or push, mostly to this device with a proper separator
  function automatic void add_request(logic push);
    int bad_pos;
    bad_pos = -1;
    if ($urandom_range(99) < 8) bad_pos = $urandom_range(ADDR_LEN - 1);
    burst.push_back(push ? CH_PUSH : CH_QUERY);
    put_address(bad_pos);
    burst.push_back(($urandom_range(99) < 6) ? filler_byte(CH_COMMA) : CH_COMMA);
    if (!push && $urandom_range(99) < 30)
      burst.push_back(CH_STAR);
    else
      burst.push_back(byte_t'($urandom_range(255)));
    // push payload runs to the end of the burst, none means an empty push
    if (push) repeat ($urandom_range(5, 0)) burst.push_back(byte_t'($urandom_range(255)));
  endfunction

  // one to three messages per burst, with noise and cut-off bursts mixed in
  task automatic random_burst();
    int   segs;
    int   kind;
    int   cut;
    int   s;
    logic closed;
    segs   = $urandom_range(3, 1);
    closed = 1'b0;
    for (s = 0; s < segs && !closed; s++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        add_time_msg();
      end else if (kind < 55) begin
        add_request(1'b0);
      end else if (kind < 80) begin
        add_request(1'b1);
        closed = 1'b1;  // a push swallows the rest of its burst
      end else begin
        repeat ($urandom_range(6, 1)) burst.push_back(byte_t'($urandom_range(255)));
      end
    end
    // burst running dry anywhere: after a lead, in the address, in the digits
    if ($urandom_range(99) < 12) begin
      cut = $urandom_range(burst.size(), 1);
      while (burst.size() > cut) void'(burst.pop_back());
    end
    send_burst();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // time broadcast corner cases
  task automatic test_broadcast_edges();
    burst = '{CH_TILDE};                            // burst ends right after the lead
    send_burst();
    burst = '{CH_TILDE, 8'hFF};                     // second byte not 'T', consumed
    send_burst();
    burst = '{CH_TILDE, CH_T};                      // empty time, accepted as zero
    send_burst();
    burst = '{CH_TILDE, CH_T, CH_NINE, 8'h00, CH_COLON};  // ':' as last byte evaluates
    send_burst();
  endtask

  // query and push corner cases at the reset address
  task automatic test_request_edges();
    burst = '{CH_QUERY};                            // lead byte alone, dropped
    send_burst();
    burst.push_back(CH_PUSH);                       // field byte last: empty push
    put_address(-1);
    burst.push_back(CH_COMMA);
    burst.push_back(8'h46);
    send_burst();
    burst.push_back(CH_QUERY);                      // describe request
    put_address(-1);
    burst.push_back(CH_COMMA);
    burst.push_back(CH_STAR);
    send_burst();
  endtask

  // new address, then random bursts under the given idling mix
  task automatic test_random_traffic(input addr_t addr, input int n_bytes,
                                     input int idle, input int stall);
    int start;
    wait_idle();
    write_address(addr);
    send_idle_pct = idle;
    stall_pct     = stall;
    start         = parsed_bytes;
    while (parsed_bytes - start < n_bytes) random_burst();
  endtask

  // receiver holds off while a long push keeps coming, then a full pause
  task automatic test_backpressure();
    int i;
    wait_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asked++;
    burst.push_back(CH_PUSH);
    put_address(-1);
    burst.push_back(CH_COMMA);
    burst.push_back(byte_t'($urandom_range(255)));
    for (i = 0; i < 40; i++) burst.push_back(byte_t'($urandom_range(255)));
    send_burst();
    // sender waits until every owed event is out
    wait_idle();
    hold_asked++;
    repeat (6) random_burst();
  endtask

  function automatic addr_t printable_address();
    addr_t a;
    int    i;
    for (i = 0; i < 4; i++) a = {a[23:0], 8'($urandom_range(8'h7E, 8'h21))};
    return a;
  endfunction

  initial begin
    reset_parser();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asked    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_broadcast_edges();
    test_request_edges();
    // address extremes, random ones and the reset address, under several idling mixes
    test_random_traffic(printable_address(), 70, 0, 0);
    test_random_traffic(32'h0000_0000, 70, 62, 0);
    test_random_traffic(32'hFFFF_FFFF, 70, 0, 62);
    test_random_traffic(addr_t'($urandom), 70, 14, 14);
    test_random_traffic(ADDR_RESET, 70, 0, 0);
    test_backpressure();

    wait_idle();
    if (mismatches == 0) begin
      $display("[addressed_serial_command_parser_unit] OK");
    end else begin
      $display("[addressed_serial_command_parser_unit] ERROR");
    end
    $finish;
  end

endmodule
